@@ rtl/core/rtnc_pkg.sv @@
// Shared constants, types and the key prefix helper for the radix tree node unit.
package rtnc_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int CODE_BITS   = 30;
    localparam int ID_BITS     = 10;
    localparam int KEY_BITS    = CODE_BITS + ID_BITS;
    localparam int POS_BITS    = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS    = 11;
    localparam int PLEN_BITS   = $clog2(KEY_BITS + 2);
    // Probe positions run past both ends of the table during the searches.
    localparam int PROBE_BITS  = POS_BITS + 4;
    localparam int SPAN_BITS   = POS_BITS + 2;

    localparam int IN_DATA_BITS  = 56;
    localparam int OUT_DATA_BITS = 48;

    typedef logic [KEY_BITS-1:0]          t_key;
    typedef logic [POS_BITS-1:0]          t_pos;
    typedef logic signed [PROBE_BITS-1:0] t_probe;
    typedef logic [SPAN_BITS-1:0]         t_span;
    // Prefix length plus one: zero stands for a position outside the table.
    typedef logic [PLEN_BITS-1:0]         t_plen;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Count leading zeros of the key difference.
    function automatic t_plen key_lzc(input t_key x);
        t_plen n;
        logic  hit;
        n   = '0;
        hit = 1'b0;
        for (int b = KEY_BITS - 1; b >= 0; b--) begin
            if (x[b]) begin
                hit = 1'b1;
            end else if (!hit) begin
                n = n + t_plen'(1);
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/core/radix_tree_node_children_unit.sv @@
// Radix tree node unit: sorted key table, range search and split search per query.
//
// Write items (tuser 0) store one {code, id} key in a single-port table. Query items
// (tuser 1) run through a sequencer that shares one table read port and one prefix
// unit (key XOR and leading-zero count); each probe is a registered table read
// (S_PROBE) followed by an evaluation (S_EVAL), and each split step adds an S_SPLIT
// state that halves the step. A query uses one key read, two direction probes, an
// exponential and a binary range search, an optional key reload, the common prefix
// probe and about log2 of the range split steps. A bad query (node index not below
// count minus one) skips the search and goes straight to the done state. The input
// side is not ready while a query runs; a finished result waits in the output register,
// and the next item is taken while it waits.
module radix_tree_node_children_unit
    import rtnc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wen,
    input  logic [CNT_BITS-1:0]      i_cfg_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // position[9:0], morton_code[39:10], body_id[49:40], zero fill
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // kind[0]
    input  logic                     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // left_child[9:0], left_is_leaf[10], right_child[20:11], right_is_leaf[21],
    // range_first[31:22], range_last[41:32], bad_query[42], zero fill
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROBE = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [2:0] P_KEYI = 3'd0;
    localparam logic [2:0] P_DIRU = 3'd1;
    localparam logic [2:0] P_DIRD = 3'd2;
    localparam logic [2:0] P_EXP  = 3'd3;
    localparam logic [2:0] P_BIN  = 3'd4;
    localparam logic [2:0] P_KEYF = 3'd5;
    localparam logic [2:0] P_COM  = 3'd6;
    localparam logic [2:0] P_SPL  = 3'd7;

    t_key mem [MAX_ENTRIES];

    logic [2:0]          r_state;
    logic [2:0]          r_phase;
    logic [CNT_BITS-1:0] r_count;
    t_pos                r_idx;
    t_key                r_key;
    t_key                r_rdata;
    t_probe              r_probe;
    logic                r_oob;
    t_plen               r_pu;
    t_plen               r_dmin;
    t_plen               r_common;
    logic                r_down;
    t_span               r_lmax;
    t_span               r_l;
    t_span               r_t;
    t_pos                r_first;
    t_pos                r_last;
    t_pos                r_split;
    t_pos                r_step;
    logic                r_bad;
    logic                r_m_valid;
    logic [OUT_DATA_BITS-1:0] r_m_data;

    logic [CNT_BITS-1:0] cnt;
    t_pos                in_pos;
    logic                in_accept;
    logic                probe_in;
    logic                rd_en;
    t_plen               plen;
    t_plen               pd_new;
    logic                down_new;
    t_span               bin_l;
    t_span               bin_t;
    t_pos                j_pos;
    t_pos                n_step;
    logic [POS_BITS:0]   spl_probe;
    logic                load_out;
    t_pos                split_inc;

    // Step a probe away from the node index in the search direction.
    function automatic t_probe walk(input t_pos base, input t_span off, input logic down);
        t_probe b;
        t_probe o;
        b = t_probe'({1'b0, base});
        o = t_probe'({1'b0, off});
        return down ? (b - o) : (b + o);
    endfunction

    assign cnt = (r_count > CNT_BITS'(MAX_ENTRIES)) ? CNT_BITS'(MAX_ENTRIES) : r_count;
    assign in_pos = s_axis_tdata[POS_BITS-1:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Range check for the probe about to read the table.
    assign probe_in = (r_probe >= 0) && (r_probe < t_probe'({1'b0, cnt}));
    assign rd_en = (r_state == S_PROBE) && probe_in;

    // Shared prefix unit.
    assign plen = r_oob ? '0 : key_lzc(r_rdata ^ r_key) + t_plen'(1);

    assign pd_new   = plen;
    assign down_new = !(r_pu >= plen);
    assign bin_l    = (plen > r_dmin) ? (r_l + r_t) : r_l;
    assign bin_t    = r_t >> 1;
    assign j_pos    = t_pos'(walk(r_idx, bin_l, r_down));
    assign n_step   = t_pos'(({1'b0, r_step} + 11'd1) >> 1);
    assign spl_probe = {1'b0, r_split} + {1'b0, n_step};
    assign split_inc = r_split + t_pos'(1);
    assign load_out = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    // Key table: write on accepted write items, registered read for probes.
    always_ff @(posedge i_clk) begin
        if (in_accept && s_axis_tuser == KIND_WRITE) begin
            mem[in_pos] <= {s_axis_tdata[POS_BITS +: CODE_BITS],
                            s_axis_tdata[POS_BITS+CODE_BITS +: ID_BITS]};
        end
        if (rd_en) begin
            r_rdata <= mem[r_probe[POS_BITS-1:0]];
        end
    end

    // Sequencer and search registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= CNT_BITS'(2);
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_count <= i_cfg_wdata;
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept && s_axis_tuser == KIND_QUERY) begin
                        r_idx   <= in_pos;
                        r_probe <= t_probe'({1'b0, in_pos});
                        r_phase <= P_KEYI;
                        if ({1'b0, in_pos} + CNT_BITS'(1) >= cnt) begin
                            r_bad   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_bad   <= 1'b0;
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    r_oob   <= !probe_in;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_state <= S_PROBE;
                    case (r_phase)
                        P_KEYI: begin
                            r_key   <= r_rdata;
                            r_probe <= walk(r_idx, t_span'(1), 1'b0);
                            r_phase <= P_DIRU;
                        end
                        P_DIRU: begin
                            r_pu    <= plen;
                            r_probe <= walk(r_idx, t_span'(1), 1'b1);
                            r_phase <= P_DIRD;
                        end
                        P_DIRD: begin
                            // Tie runs upward; dmin is the prefix on the far side.
                            r_down  <= down_new;
                            r_dmin  <= down_new ? r_pu : pd_new;
                            r_lmax  <= t_span'(2);
                            r_probe <= walk(r_idx, t_span'(2), down_new);
                            r_phase <= P_EXP;
                        end
                        P_EXP: begin
                            if (plen > r_dmin) begin
                                r_lmax  <= r_lmax << 1;
                                r_probe <= walk(r_idx, r_lmax << 1, r_down);
                            end else begin
                                r_l     <= '0;
                                r_t     <= r_lmax >> 1;
                                r_probe <= walk(r_idx, r_lmax >> 1, r_down);
                                r_phase <= P_BIN;
                            end
                        end
                        P_BIN: begin
                            r_l <= bin_l;
                            r_t <= bin_t;
                            if (bin_t != '0) begin
                                r_probe <= walk(r_idx, bin_l + bin_t, r_down);
                            end else begin
                                // Range found: pin the key of its first position.
                                r_first <= r_down ? j_pos : r_idx;
                                r_last  <= r_down ? r_idx : j_pos;
                                if (r_down) begin
                                    r_probe <= t_probe'({1'b0, j_pos});
                                    r_phase <= P_KEYF;
                                end else begin
                                    r_probe <= t_probe'({1'b0, j_pos});
                                    r_phase <= P_COM;
                                end
                            end
                        end
                        P_KEYF: begin
                            r_key   <= r_rdata;
                            r_probe <= t_probe'({1'b0, r_last});
                            r_phase <= P_COM;
                        end
                        P_COM: begin
                            r_common <= plen;
                            r_split  <= r_first;
                            r_step   <= r_last - r_first;
                            r_state  <= S_SPLIT;
                        end
                        P_SPL: begin
                            if (plen > r_common) begin
                                r_split <= r_probe[POS_BITS-1:0];
                            end
                            r_state <= (r_step > t_pos'(1)) ? S_SPLIT : S_DONE;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_SPLIT: begin
                    // Halve the step and probe only below the range end.
                    r_step <= n_step;
                    if (spl_probe < {1'b0, r_last}) begin
                        r_probe <= t_probe'(spl_probe);
                        r_phase <= P_SPL;
                        r_state <= S_PROBE;
                    end else if (n_step <= t_pos'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result register: hold until taken.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (r_bad) begin
                r_m_data <= OUT_DATA_BITS'(1) << 42;
            end else begin
                r_m_data <= {5'd0, 1'b0, r_last, r_first,
                             (split_inc == r_last), split_inc,
                             (r_split == r_first), r_split};
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the radix tree node children unit.
module tb;
    import rtnc_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int IDLE_PCT       = 13;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 600;
    localparam int ITEM_TARGET    = 1900;
    localparam int REPORT_LIMIT   = 10;
    localparam int TIMEOUT_CYCLES = 1000000;

    // Result fields, lowest bit last so the struct matches the tdata layout.
    typedef struct packed {
        logic       bad_query;
        logic [9:0] range_last;
        logic [9:0] range_first;
        logic       right_is_leaf;
        logic [9:0] right_child;
        logic       left_is_leaf;
        logic [9:0] left_child;
    } t_node_children;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wen = 1'b0;
    logic [CNT_BITS-1:0]      i_cfg_wdata = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic                     s_axis_tuser = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    // Mirror of the block state
    t_key                leaf_keys [MAX_ENTRIES];
    logic [CNT_BITS-1:0] leaf_count_reg;
    t_node_children      expected_children [$];

    int   mismatch_count = 0;
    int   sent_items = 0;
    logic quiet_link = 1'b0;
    logic hold_output = 1'b0;

    radix_tree_node_children_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Common prefix length of two table keys; -1 for a position off the table.
    function automatic int shared_prefix(input int a, input int b, input int cnt);
        t_key x;
        int   n;
        if (a < 0 || a >= cnt || b < 0 || b >= cnt) begin
            return -1;
        end
        x = leaf_keys[a] ^ leaf_keys[b];
        n = 0;
        for (int i = KEY_BITS - 1; i >= 0 && !x[i]; i--) begin
            n++;
        end
        return n;
    endfunction

    // Work out the key range, split and children of one internal node.
    function automatic t_node_children predict_children(input int node);
        t_node_children r;
        int cnt, d, dmin, lmax, l, j, first, last, common, split, step, probe;
        r   = '0;
        cnt = (int'(leaf_count_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(leaf_count_reg);
        if (node + 1 >= cnt) begin
            r.bad_query = 1'b1;
            return r;
        end
        // Head toward the neighbor with the longer shared prefix, upward on a tie.
        d    = (shared_prefix(node, node + 1, cnt) >= shared_prefix(node, node - 1, cnt))
               ? 1 : -1;
        dmin = shared_prefix(node, node - d, cnt);
        // Bound the far end, then narrow it down.
        lmax = 2;
        while (shared_prefix(node, node + lmax * d, cnt) > dmin) begin
            lmax *= 2;
        end
        l = 0;
        for (int t = lmax / 2; t >= 1; t /= 2) begin
            if (shared_prefix(node, node + (l + t) * d, cnt) > dmin) begin
                l += t;
            end
        end
        j     = node + l * d;
        first = (node < j) ? node : j;
        last  = (node > j) ? node : j;
        // Find the highest position that shares more than the common prefix.
        common = shared_prefix(first, last, cnt);
        split  = first;
        step   = last - first;
        do begin
            step  = (step + 1) >> 1;
            probe = split + step;
            if (probe < last && shared_prefix(first, probe, cnt) > common) begin
                split = probe;
            end
        end while (step > 1);
        r.left_child    = 10'(split);
        r.left_is_leaf  = (split == first);
        r.right_child   = 10'(split + 1);
        r.right_is_leaf = (split + 1 == last);
        r.range_first   = 10'(first);
        r.range_last    = 10'(last);
        return r;
    endfunction

    function automatic t_key rand_key();
        return t_key'({$urandom(), $urandom()});
    endfunction

    // Offer one item, hold it until taken, then update the mirror.
    task automatic send_item(input logic kind, input int pos, input t_key key);
        while (!quiet_link && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= IN_DATA_BITS'({key[ID_BITS-1:0], key[KEY_BITS-1:ID_BITS],
                                        t_pos'(pos)});
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
        if (kind == KIND_WRITE) begin
            leaf_keys[pos] = key;
        end else begin
            expected_children.push_back(predict_children(pos));
        end
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait for every outstanding result, then let trailing writes settle.
    task automatic wait_idle();
        while (expected_children.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_leaf_count(input int value);
        stop_sending();
        wait_idle();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= CNT_BITS'(value);
        @(posedge i_clk);
        leaf_count_reg = CNT_BITS'(value);
        i_cfg_wen <= 1'b0;
    endtask

    // Load positions 0..n-1 with ascending keys: duplicates, id-only steps and code steps.
    task automatic load_sorted_leaves(input int n);
        t_key key;
        t_key delta;
        key = rand_key() >> $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            send_item(KIND_WRITE, i, key);
            case ($urandom_range(0, 9))
                0:       delta = '0;
                1, 2, 3: delta = t_key'($urandom_range(1, 1023));
                default: delta = rand_key() >> $urandom_range(10, 39);
            endcase
            key = key + delta;
        end
    endtask

    task automatic check_field(input string field, input int want, input int seen);
        if (want != seen) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("mismatch %s: expected %0d, got %0d", field, want, seen);
            end
        end
    endtask

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_node_children seen;
        t_node_children want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = m_axis_tdata[$bits(t_node_children)-1:0];
            if (expected_children.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected result, tdata %h", m_axis_tdata);
                end
            end else begin
                want = expected_children.pop_front();
                check_field("left_child", want.left_child, seen.left_child);
                check_field("left_is_leaf", want.left_is_leaf, seen.left_is_leaf);
                check_field("right_child", want.right_child, seen.right_child);
                check_field("right_is_leaf", want.right_is_leaf, seen.right_is_leaf);
                check_field("range_first", want.range_first, seen.range_first);
                check_field("range_last", want.range_last, seen.range_last);
                check_field("bad_query", want.bad_query, seen.bad_query);
            end
        end
    end

    // Drive the result ready: random stalls, plus a long hold when requested.
    initial begin
        int held;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
                hold_output = 1'b0;
            end
            m_axis_tready <= quiet_link || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Count of two from reset: extreme keys, one good node, two bad ones.
    task automatic test_reset_pair();
        send_item(KIND_WRITE, 1023, {30'h3FFF_FFFF, 10'h3FF});
        send_item(KIND_WRITE, 0, {30'h0, 10'h0});
        send_item(KIND_WRITE, 1, {30'h3FFF_FFFF, 10'h3FF});
        send_item(KIND_QUERY, 0, '0);
        send_item(KIND_QUERY, 1, '0);
        send_item(KIND_QUERY, 1023, '0);
    endtask

    // Counts of zero and one leave no internal node; two has exactly one.
    task automatic test_tiny_counts();
        write_leaf_count(0);
        send_item(KIND_QUERY, 0, '0);
        write_leaf_count(1);
        send_item(KIND_QUERY, 0, '0);
        write_leaf_count(2);
        send_item(KIND_QUERY, 0, '0);
    endtask

    // Equal prefixes on both sides: upward search that collapses to one leaf.
    task automatic test_direction_tie();
        write_leaf_count(3);
        send_item(KIND_WRITE, 0, {30'h2000_0000, 10'h000});
        send_item(KIND_WRITE, 1, {30'h0000_0000, 10'h000});
        send_item(KIND_WRITE, 2, {30'h2000_0000, 10'h005});
        send_item(KIND_QUERY, 1, '0);
        send_item(KIND_QUERY, 0, '0);
    endtask

    // Equal codes split by id, with one fully duplicated key.
    task automatic test_equal_codes();
        write_leaf_count(4);
        send_item(KIND_WRITE, 0, {30'h1234_567, 10'h000});
        send_item(KIND_WRITE, 1, {30'h1234_567, 10'h001});
        send_item(KIND_WRITE, 2, {30'h1234_567, 10'h001});
        send_item(KIND_WRITE, 3, {30'h1234_567, 10'h3FF});
        for (int i = 0; i < 3; i++) begin
            send_item(KIND_QUERY, i, '0);
        end
    endtask

    // Full table, loaded without idling, then counts at and above the table size.
    task automatic test_full_table();
        write_leaf_count(MAX_ENTRIES);
        quiet_link = 1'b1;
        load_sorted_leaves(MAX_ENTRIES);
        quiet_link = 1'b0;
        send_item(KIND_QUERY, 0, '0);
        send_item(KIND_QUERY, MAX_ENTRIES - 2, '0);
        send_item(KIND_QUERY, MAX_ENTRIES - 1, '0);
        send_item(KIND_QUERY, MAX_ENTRIES / 2, '0);
        repeat (30) send_item(KIND_QUERY, $urandom_range(0, MAX_ENTRIES - 2), '0);
        write_leaf_count((1 << CNT_BITS) - 1);
        send_item(KIND_QUERY, MAX_ENTRIES - 2, '0);
        send_item(KIND_QUERY, MAX_ENTRIES - 1, '0);
        repeat (4) send_item(KIND_QUERY, $urandom_range(0, MAX_ENTRIES - 2), '0);
    endtask

    // Hold the result side off while queries keep coming, so the input stalls.
    task automatic test_output_backpressure();
        write_leaf_count(32);
        load_sorted_leaves(32);
        hold_output = 1'b1;
        repeat (20) send_item(KIND_QUERY, $urandom_range(0, 30), '0);
    endtask

    // Random phases: new count, mostly a fresh sorted load, some stray writes, queries.
    task automatic test_random_phases();
        int n;
        int n_eff;
        int pick;
        int queries;
        while (sent_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)       n = $urandom_range(0, 1);
            else if (pick < 63) n = $urandom_range(2, 24);
            else if (pick < 88) n = $urandom_range(25, 128);
            else if (pick < 96) n = $urandom_range(129, MAX_ENTRIES);
            else                n = $urandom_range(MAX_ENTRIES + 1, (1 << CNT_BITS) - 1);
            n_eff = (n > MAX_ENTRIES) ? MAX_ENTRIES : n;
            write_leaf_count(n);
            if (n_eff <= 128) begin
                load_sorted_leaves(n_eff);
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_item(KIND_WRITE, $urandom_range(0, MAX_ENTRIES - 1), rand_key());
                end
            end
            queries = $urandom_range(4, 20);
            repeat (queries) begin
                if (n_eff >= 2 && $urandom_range(0, 99) < 85) begin
                    send_item(KIND_QUERY, $urandom_range(0, n_eff - 2), '0);
                end else begin
                    send_item(KIND_QUERY, $urandom_range(0, MAX_ENTRIES - 1), '0);
                end
            end
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            leaf_keys[i] = '0;
        end
        leaf_count_reg = CNT_BITS'(2);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_pair();
        test_tiny_counts();
        test_direction_tie();
        test_equal_codes();
        test_full_table();
        test_output_backpressure();
        test_random_phases();

        stop_sending();
        wait_idle();
        if (mismatch_count == 0 && expected_children.size() == 0) begin
            $display("radix_tree_node_children_unit regression: pass");
        end else begin
            $display("radix_tree_node_children_unit regression: fail");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("radix_tree_node_children_unit regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rtnc_pkg.sv
rtl/core/radix_tree_node_children_unit.sv
dv/tb.sv
